/* rtl/gsb_pkg.sv */
// ============================================================================
// gsb_pkg : shared types and constants of the 3D Gram-Schmidt basis block
// Item types, fixed-point widths, pipeline depths and the Q30 rounding helper.
// ============================================================================
`default_nettype none

package gsb_pkg;

    // input component width, two's complement
    localparam int GS_IN_W   = 32;
    // unit vector component width, Q1.30
    localparam int U_W       = 32;
    localparam int FRAC      = 30;
    // block-scaled vector: magnitude in [2^29, 2^30), signed form one bit wider
    localparam int TM_W      = 30;
    localparam int T_W       = TM_W + 1;
    localparam int MSB_POS   = TM_W - 1;
    // rest vector after projection removal
    localparam int R_W       = 34;
    // projection coefficient
    localparam int P_W       = 33;
    // root and quotient widths
    localparam int L_W       = 31;
    localparam int Q_W       = 31;

    // pipeline depths
    localparam int SCALE_LAT = 3;
    localparam int NORM_LAT  = SCALE_LAT + 2 + L_W + 1 + Q_W + 1;
    localparam int PROJ_LAT  = 4;
    localparam int GS_LAT    = 3 * NORM_LAT + 2 * (SCALE_LAT + PROJ_LAT);

    typedef struct packed {
        logic signed [GS_IN_W-1:0] a_x;
        logic signed [GS_IN_W-1:0] a_y;
        logic signed [GS_IN_W-1:0] a_z;
        logic signed [GS_IN_W-1:0] b_x;
        logic signed [GS_IN_W-1:0] b_y;
        logic signed [GS_IN_W-1:0] b_z;
        logic signed [GS_IN_W-1:0] c_x;
        logic signed [GS_IN_W-1:0] c_y;
        logic signed [GS_IN_W-1:0] c_z;
    } t_gs_in;

    typedef struct packed {
        logic signed [U_W-1:0] u_x;
        logic signed [U_W-1:0] u_y;
        logic signed [U_W-1:0] u_z;
        logic signed [U_W-1:0] v_x;
        logic signed [U_W-1:0] v_y;
        logic signed [U_W-1:0] v_z;
        logic signed [U_W-1:0] w_x;
        logic signed [U_W-1:0] w_y;
        logic signed [U_W-1:0] w_z;
        logic                  degenerate;
    } t_gs_out;

    // x / 2^30, rounded to nearest, ties away from zero
    function automatic logic signed [63:0] rnd30(input logic signed [63:0] x);
        logic [63:0] m;
        m = x[63] ? 64'(-x) : 64'(x);
        m = (m + (64'd1 << (FRAC - 1))) >> FRAC;
        return x[63] ? -$signed(m) : $signed(m);
    endfunction

endpackage

`default_nettype wire

/* rtl/gram_schmidt_basis_3d.sv */
// ============================================================================
// gram_schmidt_basis_3d : pipelined Gram-Schmidt orthonormal basis
// Three input vectors in, three Q1.30 unit vectors and a degenerate flag out.
// ============================================================================
// An item passes three normalisers, two scalers and two projection pipelines.
// Throughput: one item per cycle; busy is always low.
// Each normaliser holds a 31-stage square root and a 31-stage divider.
// Synchronous reset clears the valid bits only; data registers are not reset.
// The result is shown for one cycle on o_valid; the receiver cannot stall.
`default_nettype none

module gram_schmidt_basis_3d import gsb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_gs_in  i_item,
    output logic    o_valid,
    output t_gs_out o_res
);

    typedef logic signed [U_W-1:0] t_u;

    typedef struct packed {
        logic [GS_IN_W-1:0] b_x, b_y, b_z, c_x, c_y, c_z;
    } t_s1;

    typedef struct packed {
        t_u                 u_x, u_y, u_z;
        logic [GS_IN_W-1:0] c_x, c_y, c_z;
        logic               deg;
    } t_s2;

    typedef struct packed {
        t_u   u_x, u_y, u_z, v_x, v_y, v_z;
        logic deg;
    } t_s4;

    assign busy = 1'b0;

    // first vector
    logic [GS_IN_W-1:0] a_v [3];
    t_s1                s1_in;
    logic               n1_valid;
    t_u                 n1_u [3];
    logic               n1_zero;
    logic [$bits(t_s1)-1:0] n1_side;
    t_s1                n1_s;

    assign a_v[0] = i_item.a_x;
    assign a_v[1] = i_item.a_y;
    assign a_v[2] = i_item.a_z;
    assign s1_in  = '{b_x: i_item.b_x, b_y: i_item.b_y, b_z: i_item.b_z,
                      c_x: i_item.c_x, c_y: i_item.c_y, c_z: i_item.c_z};

    gsb_norm #(
        .VW (GS_IN_W),
        .SW ($bits(t_s1))
    ) u_norm_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_v     (a_v),
        .i_side  (s1_in),
        .o_valid (n1_valid),
        .o_u     (n1_u),
        .o_zero  (n1_zero),
        .o_side  (n1_side)
    );

    assign n1_s = t_s1'(n1_side);

    // second vector: scale, remove projection on u
    logic [GS_IN_W-1:0]    b_v [3];
    t_s2                   s2_in;
    logic                  sb_valid;
    logic signed [T_W-1:0] sb_t [3];
    logic                  sb_zero;
    logic [$bits(t_s2)-1:0] sb_side;
    t_s2                   sb_s;
    t_u                    sb_u [3];

    assign b_v[0] = n1_s.b_x;
    assign b_v[1] = n1_s.b_y;
    assign b_v[2] = n1_s.b_z;
    assign s2_in  = '{u_x: n1_u[0], u_y: n1_u[1], u_z: n1_u[2],
                      c_x: n1_s.c_x, c_y: n1_s.c_y, c_z: n1_s.c_z, deg: n1_zero};

    gsb_scale #(
        .VW (GS_IN_W),
        .SW ($bits(t_s2))
    ) u_scale_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (n1_valid),
        .i_v     (b_v),
        .i_side  (s2_in),
        .o_valid (sb_valid),
        .o_t     (sb_t),
        .o_zero  (sb_zero),
        .o_side  (sb_side)
    );

    assign sb_s    = t_s2'(sb_side);
    assign sb_u[0] = sb_s.u_x;
    assign sb_u[1] = sb_s.u_y;
    assign sb_u[2] = sb_s.u_z;

    logic signed [63:0]    r_p1_prod [3];
    logic signed [T_W-1:0] r_p1_t [3];
    t_s2                   r_p1_s;
    logic signed [P_W-1:0] r_p2_p;
    logic signed [T_W-1:0] r_p2_t [3];
    t_s2                   r_p2_s;
    logic signed [63:0]    r_p3_e [3];
    logic signed [T_W-1:0] r_p3_t [3];
    t_s2                   r_p3_s;
    logic [R_W-1:0]        r_p4_r [3];
    t_s2                   r_p4_s;
    logic [3:0]            r_pv;
    t_u                    p2_u [3];

    assign p2_u[0] = r_p2_s.u_x;
    assign p2_u[1] = r_p2_s.u_y;
    assign p2_u[2] = r_p2_s.u_z;

    // projection: dot product, coefficient, scaled unit vector, rest
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_p1_prod[i] <= sb_u[i] * sb_t[i];
            r_p3_e[i]    <= r_p2_p * p2_u[i];
            r_p4_r[i]    <= R_W'(r_p3_t[i]) - R_W'(rnd30(r_p3_e[i]));
        end
        r_p1_t <= sb_t;
        r_p1_s <= sb_s;
        r_p2_p <= P_W'(rnd30(r_p1_prod[0] + r_p1_prod[1] + r_p1_prod[2]));
        r_p2_t <= r_p1_t;
        r_p2_s <= r_p1_s;
        r_p3_t <= r_p2_t;
        r_p3_s <= r_p2_s;
        r_p4_s <= r_p3_s;
    end

    // third vector rides along with u through the second normaliser
    t_s2                   n2_side_in;
    logic                  n2_valid;
    t_u                    n2_v [3];
    logic                  n2_zero;
    logic [$bits(t_s2)-1:0] n2_side;
    t_s2                   n2_s;

    assign n2_side_in = r_p4_s;

    gsb_norm #(
        .VW (R_W),
        .SW ($bits(t_s2))
    ) u_norm_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_pv[3]),
        .i_v     (r_p4_r),
        .i_side  (n2_side_in),
        .o_valid (n2_valid),
        .o_u     (n2_v),
        .o_zero  (n2_zero),
        .o_side  (n2_side)
    );

    assign n2_s = t_s2'(n2_side);

    // third vector: scale, remove projections on u and v
    logic [GS_IN_W-1:0]    c_v [3];
    t_s4                   s4_in;
    logic                  sc_valid;
    logic signed [T_W-1:0] sc_t [3];
    logic                  sc_zero;
    logic [$bits(t_s4)-1:0] sc_side;
    t_s4                   sc_s;
    t_u                    sc_u [3];
    t_u                    sc_v [3];

    assign c_v[0] = n2_s.c_x;
    assign c_v[1] = n2_s.c_y;
    assign c_v[2] = n2_s.c_z;
    assign s4_in  = '{u_x: n2_s.u_x, u_y: n2_s.u_y, u_z: n2_s.u_z,
                      v_x: n2_v[0], v_y: n2_v[1], v_z: n2_v[2],
                      deg: n2_s.deg | n2_zero};

    gsb_scale #(
        .VW (GS_IN_W),
        .SW ($bits(t_s4))
    ) u_scale_c (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (n2_valid),
        .i_v     (c_v),
        .i_side  (s4_in),
        .o_valid (sc_valid),
        .o_t     (sc_t),
        .o_zero  (sc_zero),
        .o_side  (sc_side)
    );

    assign sc_s    = t_s4'(sc_side);
    assign sc_u[0] = sc_s.u_x;
    assign sc_u[1] = sc_s.u_y;
    assign sc_u[2] = sc_s.u_z;
    assign sc_v[0] = sc_s.v_x;
    assign sc_v[1] = sc_s.v_y;
    assign sc_v[2] = sc_s.v_z;

    logic signed [63:0]    r_q1_pu [3];
    logic signed [63:0]    r_q1_pv [3];
    logic signed [T_W-1:0] r_q1_t [3];
    t_s4                   r_q1_s;
    logic signed [P_W-1:0] r_q2_p1;
    logic signed [P_W-1:0] r_q2_p2;
    logic signed [T_W-1:0] r_q2_t [3];
    t_s4                   r_q2_s;
    logic signed [63:0]    r_q3_eu [3];
    logic signed [63:0]    r_q3_ev [3];
    logic signed [T_W-1:0] r_q3_t [3];
    t_s4                   r_q3_s;
    logic [R_W-1:0]        r_q4_r [3];
    t_s4                   r_q4_s;
    logic [3:0]            r_qv;
    t_u                    q2_u [3];
    t_u                    q2_v [3];

    assign q2_u[0] = r_q2_s.u_x;
    assign q2_u[1] = r_q2_s.u_y;
    assign q2_u[2] = r_q2_s.u_z;
    assign q2_v[0] = r_q2_s.v_x;
    assign q2_v[1] = r_q2_s.v_y;
    assign q2_v[2] = r_q2_s.v_z;

    // both projections use the scaled original c
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_q1_pu[i] <= sc_u[i] * sc_t[i];
            r_q1_pv[i] <= sc_v[i] * sc_t[i];
            r_q3_eu[i] <= r_q2_p1 * q2_u[i];
            r_q3_ev[i] <= r_q2_p2 * q2_v[i];
            r_q4_r[i]  <= R_W'(r_q3_t[i]) - R_W'(rnd30(r_q3_eu[i]))
                          - R_W'(rnd30(r_q3_ev[i]));
        end
        r_q1_t  <= sc_t;
        r_q1_s  <= sc_s;
        r_q2_p1 <= P_W'(rnd30(r_q1_pu[0] + r_q1_pu[1] + r_q1_pu[2]));
        r_q2_p2 <= P_W'(rnd30(r_q1_pv[0] + r_q1_pv[1] + r_q1_pv[2]));
        r_q2_t  <= r_q1_t;
        r_q2_s  <= r_q1_s;
        r_q3_t  <= r_q2_t;
        r_q3_s  <= r_q2_s;
        r_q4_s  <= r_q3_s;
    end

    // projection valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= '0;
            r_qv <= '0;
        end else begin
            r_pv <= {r_pv[2:0], sb_valid};
            r_qv <= {r_qv[2:0], sc_valid};
        end
    end

    // third normaliser
    t_s4                   n3_side_in;
    logic                  n3_valid;
    t_u                    n3_w [3];
    logic                  n3_zero;
    logic [$bits(t_s4)-1:0] n3_side;
    t_s4                   n3_s;

    assign n3_side_in = r_q4_s;

    gsb_norm #(
        .VW (R_W),
        .SW ($bits(t_s4))
    ) u_norm_c (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_qv[3]),
        .i_v     (r_q4_r),
        .i_side  (n3_side_in),
        .o_valid (n3_valid),
        .o_u     (n3_w),
        .o_zero  (n3_zero),
        .o_side  (n3_side)
    );

    assign n3_s = t_s4'(n3_side);

    // result item straight from the last normaliser's output register
    assign o_valid = n3_valid;
    assign o_res   = '{u_x: n3_s.u_x, u_y: n3_s.u_y, u_z: n3_s.u_z,
                       v_x: n3_s.v_x, v_y: n3_s.v_y, v_z: n3_s.v_z,
                       w_x: n3_w[0], w_y: n3_w[1], w_z: n3_w[2],
                       degenerate: n3_s.deg | n3_zero};

`ifndef SYNTHESIS
    // every accepted item yields its strobe after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##(GS_LAT) o_valid)
        else $error("result strobe missing after latency");

    // no strobe without an item accepted one latency earlier
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, GS_LAT))
        else $error("result strobe without accepted item");

    // a non-degenerate basis has no all-zero vector
    a_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_res.degenerate) |->
            ((o_res.u_x != 0 || o_res.u_y != 0 || o_res.u_z != 0) &&
             (o_res.v_x != 0 || o_res.v_y != 0 || o_res.v_z != 0) &&
             (o_res.w_x != 0 || o_res.w_y != 0 || o_res.w_z != 0)))
        else $error("zero unit vector without degenerate flag");

    // first and third unit vector components stay within plus or minus one
    a_u_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |->
            (o_res.u_x <= 32'sd1073741824 && o_res.u_x >= -32'sd1073741824 &&
             o_res.u_y <= 32'sd1073741824 && o_res.u_y >= -32'sd1073741824 &&
             o_res.u_z <= 32'sd1073741824 && o_res.u_z >= -32'sd1073741824))
        else $error("first unit vector out of range");

    a_w_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |->
            (o_res.w_x <= 32'sd1073741824 && o_res.w_x >= -32'sd1073741824 &&
             o_res.w_y <= 32'sd1073741824 && o_res.w_y >= -32'sd1073741824 &&
             o_res.w_z <= 32'sd1073741824 && o_res.w_z >= -32'sd1073741824))
        else $error("third unit vector out of range");
`endif

endmodule

`default_nettype wire

/* rtl/gsb_scale.sv */
// ============================================================================
// gsb_scale : block scaling of a 3D vector
// Shifts all three components by one power of two so that the largest
// magnitude lands in [2^29, 2^30). Right shifts truncate the magnitude.
// ============================================================================
`default_nettype none

module gsb_scale import gsb_pkg::*; #(
    parameter int VW = 32,
    parameter int SW = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [VW-1:0]        i_v [3],
    input  logic [SW-1:0]        i_side,
    output logic                 o_valid,
    output logic signed [T_W-1:0] o_t [3],
    output logic                 o_zero,
    output logic [SW-1:0]        o_side
);

    localparam int PW = $clog2(VW);

    logic [VW-1:0]  r1_mag [3];
    logic [2:0]     r1_neg;
    logic [SW-1:0]  r1_side;
    logic           r1_valid;

    logic [VW-1:0]  r2_mag [3];
    logic [2:0]     r2_neg;
    logic [PW-1:0]  r2_pos;
    logic           r2_zero;
    logic [SW-1:0]  r2_side;
    logic           r2_valid;

    logic [VW-1:0]  n_or;
    logic [PW-1:0]  n_pos;
    logic signed [T_W-1:0] n_t [3];

    logic           r3_valid;

    // stage 1: magnitudes and signs
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r1_mag[i] <= i_v[i][VW-1] ? -i_v[i] : i_v[i];
            r1_neg[i] <= i_v[i][VW-1];
        end
        r1_side <= i_side;
    end

    // stage 2: leading one of the OR of magnitudes equals that of the maximum
    always_comb begin
        n_or  = r1_mag[0] | r1_mag[1] | r1_mag[2];
        n_pos = '0;
        for (int j = 0; j < VW; j++) begin
            if (n_or[j]) begin
                n_pos = PW'(j);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r2_mag  <= r1_mag;
        r2_neg  <= r1_neg;
        r2_pos  <= n_pos;
        r2_zero <= (n_or == '0);
        r2_side <= r1_side;
    end

    // stage 3: common shift, sign put back
    always_comb begin
        logic [VW-1:0]   sh;
        logic [TM_W-1:0] m;
        logic [T_W-1:0]  ext;
        for (int i = 0; i < 3; i++) begin
            if (r2_pos >= PW'(MSB_POS)) begin
                sh = r2_mag[i] >> (r2_pos - PW'(MSB_POS));
                m  = sh[TM_W-1:0];
            end else begin
                sh = '0;
                m  = r2_mag[i][TM_W-1:0] << (PW'(MSB_POS) - r2_pos);
            end
            ext    = {1'b0, m};
            n_t[i] = r2_neg[i] ? -$signed(ext) : $signed(ext);
        end
    end

    always_ff @(posedge i_clk) begin
        o_t    <= n_t;
        o_zero <= r2_zero;
        o_side <= r2_side;
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    assign o_valid = r3_valid;

endmodule

`default_nettype wire

/* rtl/gsb_norm.sv */
// ============================================================================
// gsb_norm : pipelined normalisation of a 3D vector to a Q1.30 unit vector
// Block scale, sum of squares, bit-serial square root over 31 stages and
// three restoring dividers over 31 stages. A zero vector gives zeros.
// ============================================================================
`default_nettype none

module gsb_norm import gsb_pkg::*; #(
    parameter int VW = 32,
    parameter int SW = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [VW-1:0]         i_v [3],
    input  logic [SW-1:0]         i_side,
    output logic                  o_valid,
    output logic signed [U_W-1:0] o_u [3],
    output logic                  o_zero,
    output logic [SW-1:0]         o_side
);

    localparam int RW   = 2 * L_W + 1;   // square-root remainder
    localparam int DR_W = L_W + 1;       // divider remainder
    localparam int NW   = TM_W + FRAC + 1;

    typedef struct packed {
        logic [2:0][TM_W-1:0] mag;
        logic [2:0]           neg;
        logic                 zero;
        logic [SW-1:0]        side;
    } t_carry;

    logic                  sc_valid;
    logic signed [T_W-1:0] sc_t [3];
    logic                  sc_zero;
    logic [SW-1:0]         sc_side;

    gsb_scale #(
        .VW (VW),
        .SW (SW)
    ) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_v     (i_v),
        .i_side  (i_side),
        .o_valid (sc_valid),
        .o_t     (sc_t),
        .o_zero  (sc_zero),
        .o_side  (sc_side)
    );

    // stage: squares
    t_carry                r1_c;
    logic [2*TM_W-1:0]     r1_sq [3];
    logic                  r1_valid;
    t_carry                n_c;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_c.mag[i] = sc_t[i][T_W-1] ? TM_W'(-sc_t[i]) : TM_W'(sc_t[i]);
            n_c.neg[i] = sc_t[i][T_W-1];
        end
        n_c.zero = sc_zero;
        n_c.side = sc_side;
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r1_sq[i] <= n_c.mag[i] * n_c.mag[i];
        end
        r1_c <= n_c;
    end

    // square root pipeline, index 0 holds the sum of squares
    logic [RW-1:0]  r_rem  [0:L_W];
    logic [L_W-1:0] r_root [0:L_W];
    t_carry         r_sc   [0:L_W];
    logic           r_sv   [0:L_W];

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= RW'(r1_sq[0]) + RW'(r1_sq[1]) + RW'(r1_sq[2]);
        r_root[0] <= '0;
        r_sc[0]   <= r1_c;
    end

    for (genvar k = 0; k < L_W; k++) begin : g_sqrt
        localparam int B = L_W - 1 - k;
        logic [RW-1:0] n_trial;
        logic          n_ge;

        assign n_trial = (RW'(r_root[k]) << (B + 1)) + (RW'(1) << (2 * B));
        assign n_ge    = (r_rem[k] >= n_trial);

        always_ff @(posedge i_clk) begin
            r_rem[k+1]  <= n_ge ? r_rem[k] - n_trial : r_rem[k];
            r_root[k+1] <= n_ge ? (r_root[k] | (L_W'(1) << B)) : r_root[k];
            r_sc[k+1]   <= r_sc[k];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[k+1] <= 1'b0;
            end else begin
                r_sv[k+1] <= r_sv[k];
            end
        end
    end

    // divider set-up: numerator |t| * 2^30 + L/2
    logic [DR_W-1:0] r_drem [0:Q_W][3];
    logic [Q_W-1:0]  r_dlow [0:Q_W][3];
    logic [Q_W-1:0]  r_dq   [0:Q_W][3];
    logic [L_W-1:0]  r_dl   [0:Q_W];
    t_carry          r_dc   [0:Q_W];
    logic            r_dv   [0:Q_W];

    always_ff @(posedge i_clk) begin
        logic [NW-1:0] num;
        for (int i = 0; i < 3; i++) begin
            num = (NW'(r_sc[L_W].mag[i]) << FRAC) + NW'(r_root[L_W] >> 1);
            r_drem[0][i] <= DR_W'(num >> Q_W);
            r_dlow[0][i] <= num[Q_W-1:0];
            r_dq[0][i]   <= '0;
        end
        r_dl[0] <= r_root[L_W];
        r_dc[0] <= r_sc[L_W];
    end

    for (genvar k = 0; k < Q_W; k++) begin : g_div
        logic [DR_W:0] n_rem2 [3];
        logic          n_ge   [3];

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                n_rem2[i] = {r_drem[k][i], r_dlow[k][i][Q_W-1-k]};
                n_ge[i]   = (n_rem2[i] >= (DR_W+1)'(r_dl[k]));
            end
        end

        always_ff @(posedge i_clk) begin
            for (int i = 0; i < 3; i++) begin
                r_drem[k+1][i] <= n_ge[i] ? DR_W'(n_rem2[i] - (DR_W+1)'(r_dl[k]))
                                          : DR_W'(n_rem2[i]);
                r_dlow[k+1][i] <= r_dlow[k][i];
                r_dq[k+1][i]   <= {r_dq[k][i][Q_W-2:0], n_ge[i]};
            end
            r_dl[k+1] <= r_dl[k];
            r_dc[k+1] <= r_dc[k];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k+1] <= 1'b0;
            end else begin
                r_dv[k+1] <= r_dv[k];
            end
        end
    end

    // output: clamp to one, sign back, zero vector gives zeros
    logic signed [U_W-1:0] n_u [3];
    logic                  r_ov;

    always_comb begin
        logic [Q_W-1:0] q;
        logic [U_W-1:0] ext;
        for (int i = 0; i < 3; i++) begin
            q = r_dq[Q_W][i];
            if (q > (Q_W'(1) << FRAC)) begin
                q = Q_W'(1) << FRAC;
            end
            ext = {1'b0, q};
            if (r_dc[Q_W].zero) begin
                n_u[i] = '0;
            end else begin
                n_u[i] = r_dc[Q_W].neg[i] ? -$signed(ext) : $signed(ext);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        o_u    <= n_u;
        o_zero <= r_dc[Q_W].zero;
        o_side <= r_dc[Q_W].side;
    end

    // valid bits at the stage boundaries outside the generate loops
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r_sv[0]  <= 1'b0;
            r_dv[0]  <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r1_valid <= sc_valid;
            r_sv[0]  <= r1_valid;
            r_dv[0]  <= r_sv[L_W];
            r_ov     <= r_dv[Q_W];
        end
    end

    assign o_valid = r_ov;

endmodule

`default_nettype wire

/* sim/testbench.sv */
// ============================================================================
// testbench : self-checking bench for gram_schmidt_basis_3d
// Drives matrices of three vectors, predicts the orthonormal basis in
// fixed point and compares every strobed result with the oldest prediction.
// ============================================================================
`timescale 1ns / 100ps

module testbench;
    import gsb_pkg::*;

    localparam int  N_RANDOM  = 1900;
    localparam int  DRAIN_CYC = 300;
    localparam longint LIMIT  = 400000;
    localparam longint HI     = 64'd1 << 30;
    localparam longint LO     = 64'd1 << 29;

    typedef enum int {IDLE_SEND, IDLE_RECV, IDLE_NONE} t_idle_phase;

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    t_gs_in   i_item;
    logic     o_valid;
    t_gs_out  o_res;

    t_gs_in   pending_items[$];
    t_gs_out  expected_bases[$];
    int       n_sent;
    bit       failed;
    bit       stim_done;
    longint   cycle_cnt;
    t_idle_phase idle_phase;

    gram_schmidt_basis_3d dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    // ------------------------------------------------------------------
    // basis predictor
    // ------------------------------------------------------------------
    function automatic longint unsigned magn(longint x);
        return x < 0 ? 64'(-x) : 64'(x);
    endfunction

    function automatic longint sgn_of(longint unsigned m, bit neg);
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint round_q30(longint x);
        longint unsigned m;
        m = (magn(x) + LO) >> 30;
        return sgn_of(m, x < 0);
    endfunction

    // scale so the largest magnitude lands in [2^29, 2^30)
    function automatic bit scale_block(input longint v[3], output longint t[3]);
        longint unsigned m;
        int k;
        m = 0;
        k = 0;
        for (int i = 0; i < 3; i++) if (magn(v[i]) > m) m = magn(v[i]);
        if (m == 0) begin
            for (int i = 0; i < 3; i++) t[i] = 0;
            return 0;
        end
        if (m >= HI) begin
            while ((m >> k) >= HI) k++;
            for (int i = 0; i < 3; i++) t[i] = sgn_of(magn(v[i]) >> k, v[i] < 0);
        end else begin
            while ((m << k) < LO) k++;
            for (int i = 0; i < 3; i++) t[i] = sgn_of(magn(v[i]) << k, v[i] < 0);
        end
        return 1;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned s);
        longint unsigned res, bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > s) bt >>= 2;
        while (bt != 0) begin
            if (s >= res + bt) begin
                s -= res + bt;
                res = (res >> 1) + bt;
            end else begin
                res >>= 1;
            end
            bt >>= 2;
        end
        return res;
    endfunction

    // returns 1 when the vector is exactly zero
    function automatic bit to_unit(input longint v[3], output longint u[3]);
        longint t[3];
        longint unsigned s, len, q;
        s = 0;
        if (!scale_block(v, t)) begin
            for (int i = 0; i < 3; i++) u[i] = 0;
            return 1;
        end
        for (int i = 0; i < 3; i++) s += magn(t[i]) * magn(t[i]);
        len = int_sqrt(s);
        for (int i = 0; i < 3; i++) begin
            q = ((magn(t[i]) << 30) + (len >> 1)) / len;
            if (q > HI) q = HI;
            u[i] = sgn_of(q, t[i] < 0);
        end
        return 0;
    endfunction

    function automatic longint proj_on(input longint e[3], input longint t[3]);
        return round_q30(e[0] * t[0] + e[1] * t[1] + e[2] * t[2]);
    endfunction

    function automatic t_gs_out predict_basis(t_gs_in it);
        longint a[3], b[3], c[3], u[3], v[3], w[3], t[3], r[3];
        longint p1, p2;
        bit deg;
        t_gs_out o;
        a = '{it.a_x, it.a_y, it.a_z};
        b = '{it.b_x, it.b_y, it.b_z};
        c = '{it.c_x, it.c_y, it.c_z};
        deg = to_unit(a, u);
        void'(scale_block(b, t));
        p1 = proj_on(u, t);
        for (int i = 0; i < 3; i++) r[i] = t[i] - round_q30(p1 * u[i]);
        deg = to_unit(r, v) | deg;
        void'(scale_block(c, t));
        p1 = proj_on(u, t);
        p2 = proj_on(v, t);
        for (int i = 0; i < 3; i++)
            r[i] = t[i] - round_q30(p1 * u[i]) - round_q30(p2 * v[i]);
        deg = to_unit(r, w) | deg;
        o.u_x = u[0][31:0]; o.u_y = u[1][31:0]; o.u_z = u[2][31:0];
        o.v_x = v[0][31:0]; o.v_y = v[1][31:0]; o.v_z = v[2][31:0];
        o.w_x = w[0][31:0]; o.w_y = w[1][31:0]; o.w_z = w[2][31:0];
        o.degenerate = deg;
        return o;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [31:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 32'($urandom);
            1: return 32'($signed($urandom_range(0, 40)) - 20);
            2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            3: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            4: return 32'($urandom) >>> $urandom_range(0, 31);
            default: return 32'($urandom);
        endcase
    endfunction

    function automatic t_gs_in rand_matrix();
        t_gs_in it;
        it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom};
        it.a_x = rand_comp(); it.a_y = rand_comp(); it.a_z = rand_comp();
        it.b_x = rand_comp(); it.b_y = rand_comp(); it.b_z = rand_comp();
        it.c_x = rand_comp(); it.c_y = rand_comp(); it.c_z = rand_comp();
        // some zero vectors and parallel pairs to hit the degenerate paths
        case ($urandom_range(0, 9))
            0: {it.a_x, it.a_y, it.a_z} = '0;
            1: {it.b_x, it.b_y, it.b_z} = {it.a_x, it.a_y, it.a_z};
            2: {it.c_x, it.c_y, it.c_z} = {it.b_x, it.b_y, it.b_z};
            3: {it.b_x, it.b_y, it.b_z} = '0;
            4: {it.c_x, it.c_y, it.c_z} = '0;
            default: ;
        endcase
        return it;
    endfunction

    function automatic t_gs_in mk(longint ax, ay, az, bx, by, bz, cx, cy, cz);
        t_gs_in it;
        it = {ax[31:0], ay[31:0], az[31:0], bx[31:0], by[31:0], bz[31:0],
              cx[31:0], cy[31:0], cz[31:0]};
        return it;
    endfunction

    // ------------------------------------------------------------------
    // clock, reset and stimulus list
    // ------------------------------------------------------------------
    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
    end

    initial begin
        // directed matrices
        pending_items.push_back(mk(65536, 0, 0, 0, 65536, 0, 0, 0, 65536));
        pending_items.push_back(mk(0, 0, 0, 1, 2, 3, 4, 5, 6));
        pending_items.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(mk(1, 2, 3, 2, 4, 6, 7, 1, 5));
        pending_items.push_back(mk(1, 2, 3, 4, 5, 6, 5, 7, 9));
        pending_items.push_back(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                   32'h80000000, 32'h80000000, 32'h80000000,
                                   32'h7fffffff, 32'h80000000, 0));
        pending_items.push_back(mk(-2147483648, 0, 0, 0, -2147483648, 0,
                                   0, 0, -2147483648));
        pending_items.push_back(mk(1, 0, 0, 0, 1, 0, 0, 0, 1));
        pending_items.push_back(mk(-1, -1, -1, 1, -1, 0, 0, 0, 0));
        pending_items.push_back(mk(1000000, 1, 0, 1000000, 0, 0, 3, 3, 3));
        pending_items.push_back(mk(3, 4, 0, 0, 0, 0, 0, 0, 7));
        pending_items.push_back(mk(-1, 0, 0, 1, 0, 0, -1, 0, 0));
        pending_items.push_back(mk(123456789, -987654, 55, -7, 9, 1 << 20,
                                   -2147483647, 2147483647, 1));
        for (int i = 0; i < N_RANDOM; i++) pending_items.push_back(rand_matrix());
        stim_done = 1;
    end

    // ------------------------------------------------------------------
    // driver
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start  <= 1'b0;
            i_item <= '0;
        end else begin
            // item taken at this edge if start was high and busy low
            if (start && !busy) begin
                expected_bases.push_back(predict_basis(i_item));
                n_sent <= n_sent + 1;
            end
            if ((!start || !busy) && pending_items.size() > 0 &&
                !(idle_phase == IDLE_SEND && $urandom_range(0, 99) < 6) &&
                !(idle_phase == IDLE_RECV && $urandom_range(0, 99) < 45)) begin
                start  <= 1'b1;
                i_item <= pending_items.pop_front();
            end else if (!start || !busy) begin
                start <= 1'b0;
            end
        end
    end

    initial begin
        start = 0;
        i_item = '0;
        n_sent = 0;
        failed = 0;
        cycle_cnt = 0;
        idle_phase = IDLE_SEND;
    end

    // idle pattern advances with the items sent
    always @(posedge i_clk) begin
        if (n_sent > 2 * N_RANDOM / 3)
            idle_phase <= IDLE_NONE;
        else if (n_sent > N_RANDOM / 3)
            idle_phase <= IDLE_RECV;
    end

    // ------------------------------------------------------------------
    // monitor
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_gs_out exp_b;
        if (i_rst_n && o_valid) begin
            if (expected_bases.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_res);
                failed <= 1'b1;
            end else begin
                exp_b = expected_bases.pop_front();
                if (o_res !== exp_b) begin
                    $display("%0t: mismatch expected %h actual %h", $time, exp_b, o_res);
                    failed <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // end of run and timeout
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        wait (stim_done);
        @(posedge i_clk);
        while (pending_items.size() > 0 || start) @(posedge i_clk);
        while (expected_bases.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (!failed && expected_bases.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* files.f */
rtl/gsb_pkg.sv
rtl/gsb_scale.sv
rtl/gsb_norm.sv
rtl/gram_schmidt_basis_3d.sv
sim/testbench.sv
